// ===== rtl/core/cbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared widths, types and reset values of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  localparam int U_FRAC_BITS = 12;
  localparam int COORD_WIDTH = 16;

  localparam int UW   = U_FRAC_BITS + 1;
  localparam int SQW  = 2 * UW;
  localparam int T3W  = UW + 2;
  localparam int WW   = 3 * U_FRAC_BITS + 1;
  localparam int RSH  = 3 * U_FRAC_BITS;
  localparam int PW   = WW + 1 + COORD_WIDTH;
  localparam int SW   = PW + 2;
  localparam int RW   = SW - RSH;

  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = REG_AW + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [COORD_WIDTH-1:0] CTRL_RST [NUM_REGS] = '{
    COORD_WIDTH'(-16384), COORD_WIDTH'(0),
    COORD_WIDTH'(-8192),  COORD_WIDTH'(-8192),
    COORD_WIDTH'(8192),   COORD_WIDTH'(8192),
    COORD_WIDTH'(16384),  COORD_WIDTH'(0)
  };

  typedef struct packed {
    logic [3:0][WW-1:0] w;
  } weights_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/cbpe_front.sv =====
// ----------------------------------------------------------------------------
// cbpe_front
// Clamps the curve parameter and forms the four Bernstein weights.
// ----------------------------------------------------------------------------
module cbpe_front
  import cbpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [UW-1:0]       param_u_i,
  input  q_stat_t             q_stat_i,
  output logic                push_o,
  output weights_t            wdata_o
);

  localparam logic [UW-1:0] ONE = {1'b1, {U_FRAC_BITS{1'b0}}};

  logic              fe_en;
  logic              f0_vld_q, f1_vld_q, f2_vld_q;
  logic [UW-1:0]     u0_q, v0_q, u0_d, v0_d;
  logic [SQW-1:0]    uu_q, vv_q;
  logic [UW-1:0]     u1_q, v1_q;
  logic [T3W-1:0]    u3_q, v3_q;
  logic [SQW+T3W-1:0] m0, m1, m2, m3;
  weights_t          w_q;

  assign fe_en      = !q_stat_i.full || !f2_vld_q;
  assign in_stall_o = !fe_en;
  assign push_o     = f2_vld_q && !q_stat_i.full;
  assign wdata_o    = w_q;

  assign u0_d = (param_u_i > ONE) ? ONE : param_u_i;
  assign v0_d = ONE - u0_d;

  assign m0 = (SQW+T3W)'(vv_q * v1_q);
  assign m1 = (SQW+T3W)'(vv_q * u3_q);
  assign m2 = (SQW+T3W)'(uu_q * v3_q);
  assign m3 = (SQW+T3W)'(uu_q * u1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (fe_en) begin
      f0_vld_q <= in_valid_i;
      f1_vld_q <= f0_vld_q;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe_en) begin
      u0_q    <= u0_d;
      v0_q    <= v0_d;
      uu_q    <= SQW'(u0_q * u0_q);
      vv_q    <= SQW'(v0_q * v0_q);
      u1_q    <= u0_q;
      v1_q    <= v0_q;
      u3_q    <= T3W'({u0_q, 1'b0}) + T3W'(u0_q);
      v3_q    <= T3W'({v0_q, 1'b0}) + T3W'(v0_q);
      w_q.w[0] <= m0[WW-1:0];
      w_q.w[1] <= m1[WW-1:0];
      w_q.w[2] <= m2[WW-1:0];
      w_q.w[3] <= m3[WW-1:0];
    end
  end

endmodule

// ===== rtl/core/cbpe_queue.sv =====
// ----------------------------------------------------------------------------
// cbpe_queue
// Short queue of weight words between the front and the back.
// ----------------------------------------------------------------------------
module cbpe_queue
  import cbpe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  weights_t  wdata_i,
  input  logic      pop_i,
  output weights_t  rdata_o,
  output q_stat_t   stat_o
);

  weights_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0]   cnt_q;

  assign stat_o.full  = (cnt_q == Q_CW'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + Q_CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty)) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/cbpe_back.sv =====
// ----------------------------------------------------------------------------
// cbpe_back
// Holds the control points and forms the rounded, saturated weighted sums.
// ----------------------------------------------------------------------------
module cbpe_back
  import cbpe_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  q_stat_t                       q_stat_i,
  input  weights_t                      rdata_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o
);

  localparam logic signed [SW-1:0] HALF = {{(SW-RSH){1'b0}}, 1'b1, {(RSH-1){1'b0}}};
  localparam logic signed [RW-1:0] MAXV = {{(RW-COORD_WIDTH+1){1'b0}},
                                           {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = {{(RW-COORD_WIDTH+1){1'b1}},
                                           {(COORD_WIDTH-1){1'b0}}};

  logic [COORD_WIDTH-1:0]          regs_q [NUM_REGS];
  logic                            be_en;
  logic                            b1_vld_q, b2_vld_q, out_vld_q;
  logic signed [PW-1:0]            px_q [4], py_q [4], px_d [4], py_d [4];
  logic signed [PW:0]              sx01_q, sx23_q, sy01_q, sy23_q;
  logic signed [SW-1:0]            tot_x, tot_y;
  logic signed [RW-1:0]            rnd_x, rnd_y, sat_x, sat_y;
  logic signed [COORD_WIDTH-1:0]   pt_x_q, pt_y_q;

  assign be_en       = !out_vld_q || !out_stall_i;
  assign pop_o       = !q_stat_i.empty && be_en;
  assign out_valid_o = out_vld_q;
  assign point_x_o   = pt_x_q;
  assign point_y_o   = pt_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= CTRL_RST[i];
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_index_i[REG_AW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px_d[i] = $signed({1'b0, rdata_i.w[i]}) * $signed(regs_q[2*i]);
      py_d[i] = $signed({1'b0, rdata_i.w[i]}) * $signed(regs_q[2*i+1]);
    end
  end

  always_comb begin
    tot_x = SW'(sx01_q) + SW'(sx23_q) + HALF;
    tot_y = SW'(sy01_q) + SW'(sy23_q) + HALF;
    rnd_x = tot_x[SW-1:RSH];
    rnd_y = tot_y[SW-1:RSH];
    sat_x = (rnd_x > MAXV) ? MAXV : ((rnd_x < MINV) ? MINV : rnd_x);
    sat_y = (rnd_y > MAXV) ? MAXV : ((rnd_y < MINV) ? MINV : rnd_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (be_en) begin
      b1_vld_q  <= pop_o;
      b2_vld_q  <= b1_vld_q;
      out_vld_q <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_en) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= px_d[i];
        py_q[i] <= py_d[i];
      end
      sx01_q <= (PW+1)'(px_q[0]) + (PW+1)'(px_q[1]);
      sx23_q <= (PW+1)'(px_q[2]) + (PW+1)'(px_q[3]);
      sy01_q <= (PW+1)'(py_q[0]) + (PW+1)'(py_q[1]);
      sy23_q <= (PW+1)'(py_q[2]) + (PW+1)'(py_q[3]);
      pt_x_q <= sat_x[COORD_WIDTH-1:0];
      pt_y_q <= sat_y[COORD_WIDTH-1:0];
    end
  end

`ifndef SYNTHESIS
  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> b1_vld_q) else $error("popped word not taken by first stage");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(pt_x_q) && $stable(pt_y_q)))
    else $error("result changed while stalled");
`endif

endmodule

// ===== rtl/core/cubic_bezier_point_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_evaluator_top
// Evaluates one point of a planar cubic Bezier curve per curve parameter.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  param_u_i
//   out       source     out_valid_o/out_stall_i point_x_o, point_y_o
//   cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one word per cycle sustained unless stalled; out_valid_o rises after the accepting
// edge: 3 weight stages, one queue slot, product, pair sum, round/saturate reg
// reset clears all valid state and loads the default control points
// output stall freezes the back and fills the queue; the front stalls once
// the queue is full and its last weight stage holds a word
// ----------------------------------------------------------------------------
module cubic_bezier_point_evaluator_top
  import cbpe_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [UW-1:0]                 param_u_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] point_x_o,
  output logic signed [COORD_WIDTH-1:0] point_y_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i
);

  q_stat_t  q_stat;
  logic     push, pop;
  weights_t wdata, rdata;

  assign cfg_ready_o = 1'b1;

  cbpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .param_u_i  (param_u_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .wdata_o    (wdata)
  );

  cbpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .rdata_o (rdata),
    .stat_o  (q_stat)
  );

  cbpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .rdata_i     (rdata),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o)
  );

endmodule

// ===== bench/cubic_bezier_point_evaluator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_evaluator_top_tb
// Self-checking bench for the cubic Bezier point evaluator. Each accepted
// curve parameter is run through a local Bernstein blend predictor and the
// returned point is compared field by field in order. Directed tests cover
// endpoints, parameters above one, rounding ties, coordinate extremes and
// out-of-range register writes; random traffic then runs under several
// sender and receiver idle mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module cubic_bezier_point_evaluator_top_tb;
  import cbpe_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int MAX_GAP        = 30;
  localparam int PHASE_WORDS    = 200;
  localparam int PRESSURE_WORDS = 48;
  localparam int U_ONE          = 1 << U_FRAC_BITS;

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL0_X, REG_CTRL0_Y, REG_CTRL1_X, REG_CTRL1_Y,
    REG_CTRL2_X, REG_CTRL2_Y, REG_CTRL3_X, REG_CTRL3_Y
  } reg_idx_e;

  typedef struct packed {
    logic [UW-1:0]                 u;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } point_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [UW-1:0]                 param_u = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [COORD_WIDTH-1:0]        cfg_data = '0;

  logic signed [COORD_WIDTH-1:0] ctrl_pts [NUM_REGS];
  logic signed [COORD_WIDTH-1:0] cfg_stage [NUM_REGS];
  point_t                        point_q [$];
  int                            mismatch_cnt = 0;
  int                            quiet_cycles = 0;
  int                            idle_pct = 0;
  int                            stall_pct = 0;
  int                            hold_left = 0;

  cubic_bezier_point_evaluator_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .param_u_i   (param_u),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic signed [COORD_WIDTH-1:0] round_sat(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (RSH - 1))) >>> RSH;
    if (r > C_MAX) r = C_MAX;
    if (r < C_MIN) r = C_MIN;
    return COORD_WIDTH'(r);
  endfunction

  function automatic point_t bezier_point(logic [UW-1:0] u_in);
    longint t, s, ax, ay;
    longint w [4];
    point_t p;
    t = (u_in > U_ONE) ? U_ONE : u_in;
    s = U_ONE - t;
    w[0] = s * s * s;
    w[1] = 3 * t * s * s;
    w[2] = 3 * t * t * s;
    w[3] = t * t * t;
    ax = 0;
    ay = 0;
    for (int i = 0; i < 4; i++) begin
      ax += w[i] * ctrl_pts[2*i];
      ay += w[i] * ctrl_pts[2*i+1];
    end
    p.u = u_in;
    p.x = round_sat(ax);
    p.y = round_sat(ay);
    return p;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return COORD_WIDTH'($urandom_range(64)) - COORD_WIDTH'(32);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [UW-1:0] pick_param();
    case ($urandom_range(15))
      0:       return '0;
      1:       return UW'(U_ONE);
      2:       return UW'($urandom);
      3:       return UW'($urandom_range(U_ONE + 1, (1 << UW) - 1));
      default: return UW'($urandom_range(U_ONE));
    endcase
  endfunction

  // receiver: random stall, or a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      if (point_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word expected none actual x=%0d y=%0d",
                 $time, point_x, point_y);
      end else begin
        exp_pt = point_q.pop_front();
        if (point_x !== exp_pt.x) begin
          mismatch_cnt++;
          $display("%0t: point_x (u=%0d) expected %0d actual %0d",
                   $time, exp_pt.u, exp_pt.x, point_x);
        end
        if (point_y !== exp_pt.y) begin
          mismatch_cnt++;
          $display("%0t: point_y (u=%0d) expected %0d actual %0d",
                   $time, exp_pt.u, exp_pt.y, point_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(logic [UW-1:0] u);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    param_u  <= u;
    do @(posedge clk); while (in_stall);
    point_q.push_back(bezier_point(u));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) ctrl_pts[idx] = data;
  endtask

  task automatic load_points();
    for (int i = REG_CTRL0_X; i <= REG_CTRL3_Y; i++)
      cfg_write(CFG_IDX_W'(i), cfg_stage[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_points();
    logic [UW-1:0] u_list [10] = '{0, 4096, 2048, 1, 4095, 4097, 8191, 6144, 1024, 3072};
    foreach (u_list[i]) send_word(u_list[i]);
    drain();
  endtask

  task automatic test_rounding_ties();
    foreach (cfg_stage[i]) cfg_stage[i] = '0;
    // u = 1/2 gives P0 weight 1/8: +4 lands on +0.5, -4 on -0.5
    cfg_stage[REG_CTRL0_X] = 4;
    cfg_stage[REG_CTRL0_Y] = -4;
    load_points();
    send_word(UW'(U_ONE / 2));
    send_word('0);
    send_word(UW'(U_ONE));
    drain();
  endtask

  task automatic test_coord_extremes();
    logic [UW-1:0] u_list [4] = '{0, 2048, 4096, 8191};
    foreach (cfg_stage[i]) cfg_stage[i] = C_MAX;
    load_points();
    foreach (u_list[i]) send_word(u_list[i]);
    drain();
    foreach (cfg_stage[i]) cfg_stage[i] = C_MIN;
    load_points();
    foreach (u_list[i]) send_word(u_list[i]);
    drain();
    foreach (cfg_stage[i])
      cfg_stage[i] = (((i / 2) == 0 || (i / 2) == 3) ^ (i % 2)) ? C_MAX : C_MIN;
    load_points();
    send_word(UW'(1365));
    drain();
  endtask

  task automatic test_bad_index();
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), COORD_WIDTH'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_word(UW'(U_ONE / 4));
    send_word(UW'(U_ONE / 2));
    drain();
  endtask

  task automatic test_random_traffic(int sender_idle, int receiver_stall);
    foreach (cfg_stage[i]) cfg_stage[i] = pick_coord();
    load_points();
    cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              COORD_WIDTH'($urandom));
    cfg_valid <= 1'b0;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (PHASE_WORDS) send_word(pick_param());
    drain();
  endtask

  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (PRESSURE_WORDS) send_word(pick_param());
    drain();
  endtask

  initial begin
    foreach (ctrl_pts[i]) ctrl_pts[i] = CTRL_RST[i];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_points();
    test_rounding_ties();
    test_coord_extremes();
    test_bad_index();
    test_random_traffic(0, 0);
    test_random_traffic(74, 0);
    test_random_traffic(0, 74);
    test_random_traffic(21, 21);
    test_output_hold();

    if (mismatch_cnt == 0 && point_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
